// ===== src/gsuf_pkg.sv =====
// shared types and constants for the graph segment union-find engine
`default_nettype none
package gsuf_pkg;

  localparam int unsigned VertexBits = 16;
  localparam int unsigned Depth      = 1 << VertexBits;
  localparam int unsigned SizeBits   = 17;
  localparam int unsigned RankBits   = 5;
  localparam int unsigned ThrBits    = 24;
  localparam int unsigned WeightBits = 18;

  localparam logic [SizeBits-1:0] SizeMax  = '1;
  localparam logic [RankBits-1:0] RankMax  = '1;
  localparam logic [ThrBits-1:0]  ThrMax   = '1;
  localparam logic [SizeBits-1:0] SetReset = SizeBits'(Depth);

  typedef enum logic [1:0] {
    ACT_SEGMENT = 2'd0,
    ACT_SMALL   = 2'd1,
    ACT_QUERY   = 2'd2,
    ACT_SPARE   = 2'd3
  } action_e;

  typedef enum logic [0:0] {
    REG_MERGE_CONST = 1'b0,
    REG_MIN_SIZE    = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]            action;
    logic [VertexBits-1:0] vertex_a;
    logic [VertexBits-1:0] vertex_b;
    logic [WeightBits-1:0] edge_weight;
  } in_item_t;

  typedef struct packed {
    logic                  merged;
    logic [VertexBits-1:0] label;
    logic [SizeBits-1:0]   segment_size;
    logic [SizeBits-1:0]   set_count;
  } out_item_t;

  // one vertex entry of the forest: parent, rank, size
  typedef struct packed {
    logic [VertexBits-1:0] parent;
    logic [RankBits-1:0]   rank;
    logic [SizeBits-1:0]   size;
  } node_t;

  // threshold entry with its written mark
  typedef struct packed {
    logic               written;
    logic [ThrBits-1:0] thr;
  } thr_ent_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE,
    ST_FA_RD, ST_FA_WT, ST_FA_STEP, ST_FA_FIX,
    ST_FB_RD, ST_FB_WT, ST_FB_STEP, ST_FB_FIX,
    ST_RA_RD, ST_RA_WT, ST_RB_RD, ST_RB_WT,
    ST_JOIN, ST_DIV, ST_THR_WR, ST_LBL_RD, ST_LBL_WT, ST_OUT
  } state_e;

endpackage
`default_nettype wire

// ===== src/graph_segment_union_find_top.sv =====
// top level of the graph segment union-find engine
// time from accept to result grows with the work: an edge walks from both ends, an edge whose
// ends lie in different sets also reads both roots, and a segment merge waits for the threshold
// divide; each parent step walked and each endpoint that is not its own root adds to it
// throughput: one item at a time; a held result keeps the engine in its last state
// reset: a clearing pass rewrites every entry before the first item is taken; registers reset
// to zero, set count to the vertex count, configuration taken throughout
`default_nettype none
module graph_segment_union_find_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire gsuf_pkg::in_item_t           in_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output gsuf_pkg::out_item_t               out_data_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [0:0]                   cfg_index_i,
  input  wire logic [31:0]                  cfg_data_i
);
  import gsuf_pkg::*;

  state_e state_q, state_d;

  logic [ThrBits-1:0]  mconst_q;
  logic [SizeBits-1:0] minsz_q;
  logic [SizeBits-1:0] sets_q, sets_d;
  logic [VertexBits:0] clr_q, clr_d;

  in_item_t  item_q, item_d;
  out_item_t res_q, res_d;
  // output beat register, apart from the working result
  out_item_t out_q, out_d;
  logic      res_vld_q, res_vld_d;

  // walk registers: current vertex, roots, root entries
  logic [VertexBits-1:0] cur_q, cur_d;
  logic [VertexBits-1:0] ra_q, ra_d, rb_q, rb_d, root_q, root_d;
  node_t                 na_q, na_d, nb_q, nb_d;
  logic [ThrBits-1:0]    ta_q, ta_d;

  // node memory and threshold memory ports
  logic                  n_we, t_we;
  logic [VertexBits-1:0] n_addr, t_addr;
  node_t                 n_wdata, n_rdata;
  thr_ent_t              t_wdata, t_rdata;

  // divider
  logic                div_start, div_done;
  logic [ThrBits-1:0]  div_quo;

  logic                  edge_act, join_ok, a_wins;
  logic [SizeBits:0]     sum_sz;
  logic [SizeBits-1:0]   sat_sz;
  logic [ThrBits-1:0]    thr_rd;
  logic [ThrBits:0]      thr_sum;

  gsuf_ram #(.AddrBits(VertexBits), .DataBits($bits(node_t))) u_node_ram (
    .clk_i, .we_i(n_we), .addr_i(n_addr), .wdata_i(n_wdata), .rdata_o(n_rdata)
  );

  gsuf_ram #(.AddrBits(VertexBits), .DataBits($bits(thr_ent_t))) u_thr_ram (
    .clk_i, .we_i(t_we), .addr_i(t_addr), .wdata_i(t_wdata), .rdata_o(t_rdata)
  );

  // divisor is the merged size, taken while the join is decided
  gsuf_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(mconst_q), .den_i(sat_sz),
    .done_o(div_done), .quo_o(div_quo)
  );

  assign edge_act = (item_q.action == ACT_SEGMENT) || (item_q.action == ACT_SMALL);
  // unwritten threshold entries read as the live merge constant
  assign thr_rd   = t_rdata.written ? t_rdata.thr : mconst_q;
  assign sum_sz   = {1'b0, na_q.size} + {1'b0, nb_q.size};
  assign sat_sz   = sum_sz[SizeBits] ? SizeMax : sum_sz[SizeBits-1:0];
  assign a_wins   = na_q.rank > nb_q.rank;
  assign thr_sum  = {{(ThrBits-WeightBits+1){1'b0}}, item_q.edge_weight} + {1'b0, div_quo};

  always_comb begin
    if (item_q.action == ACT_SEGMENT) begin
      join_ok = ({6'd0, item_q.edge_weight} <= ta_q) &&
                ({6'd0, item_q.edge_weight} <= thr_rd);
    end else begin
      join_ok = (na_q.size < minsz_q) || (nb_q.size < minsz_q);
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = res_vld_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d   = state_q;
    sets_d    = sets_q;
    clr_d     = clr_q;
    item_d    = item_q;
    res_d     = res_q;
    out_d     = out_q;
    res_vld_d = res_vld_q && out_stall_i;
    cur_d     = cur_q;
    ra_d      = ra_q;
    rb_d      = rb_q;
    root_d    = root_q;
    na_d      = na_q;
    nb_d      = nb_q;
    ta_d      = ta_q;
    n_we      = 1'b0;
    t_we      = 1'b0;
    n_addr    = cur_q;
    t_addr    = cur_q;
    n_wdata   = n_rdata;
    t_wdata   = '0;
    div_start = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        // sweep every entry back to a singleton
        n_we    = 1'b1;
        t_we    = 1'b1;
        n_addr  = clr_q[VertexBits-1:0];
        t_addr  = clr_q[VertexBits-1:0];
        n_wdata = '{parent: clr_q[VertexBits-1:0], rank: '0, size: SizeBits'(1)};
        clr_d   = clr_q + 1'b1;
        if (clr_q == (VertexBits+1)'(Depth - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i && !in_stall_o) begin
          item_d  = in_data_i;
          cur_d   = in_data_i.vertex_a;
          state_d = ST_FA_RD;
        end
      end
      ST_FA_RD: begin
        n_addr  = cur_q;
        state_d = ST_FA_WT;
      end
      ST_FA_WT: begin
        state_d = ST_FA_STEP;
      end
      ST_FA_STEP: begin
        if (n_rdata.parent == cur_q) begin
          root_d  = cur_q;
          state_d = ST_FA_FIX;
        end else begin
          cur_d   = n_rdata.parent;
          n_addr  = n_rdata.parent;
          state_d = ST_FA_WT;
        end
      end
      ST_FA_FIX: begin
        // compress only the queried vertex
        n_addr  = item_q.vertex_a;
        state_d = ST_FA_FIX;
        if (cur_q != item_q.vertex_a) begin
          cur_d   = item_q.vertex_a;
          state_d = ST_FA_FIX;
        end else begin
          ra_d = root_q;
          if (edge_act) begin
            cur_d   = item_q.vertex_b;
            state_d = ST_FB_RD;
          end else begin
            cur_d   = root_q;
            state_d = ST_LBL_RD;
          end
        end
        if (cur_q == item_q.vertex_a) begin
          n_we    = 1'b1;
          n_wdata = '{parent: root_q, rank: n_rdata.rank, size: n_rdata.size};
        end
      end
      ST_FB_RD: begin
        n_addr  = cur_q;
        state_d = ST_FB_WT;
      end
      ST_FB_WT: begin
        state_d = ST_FB_STEP;
      end
      ST_FB_STEP: begin
        if (n_rdata.parent == cur_q) begin
          root_d  = cur_q;
          state_d = ST_FB_FIX;
        end else begin
          cur_d   = n_rdata.parent;
          n_addr  = n_rdata.parent;
          state_d = ST_FB_WT;
        end
      end
      ST_FB_FIX: begin
        n_addr = item_q.vertex_b;
        if (cur_q != item_q.vertex_b) begin
          cur_d = item_q.vertex_b;
        end else begin
          n_we    = 1'b1;
          n_wdata = '{parent: root_q, rank: n_rdata.rank, size: n_rdata.size};
          rb_d    = root_q;
          cur_d   = ra_q;
          if (root_q == ra_q) begin
            state_d = ST_LBL_RD;
          end else begin
            state_d = ST_RA_RD;
          end
        end
      end
      ST_RA_RD: begin
        n_addr  = ra_q;
        t_addr  = ra_q;
        state_d = ST_RA_WT;
      end
      ST_RA_WT: begin
        na_d    = n_rdata;
        ta_d    = thr_rd;
        n_addr  = rb_q;
        t_addr  = rb_q;
        state_d = ST_RB_RD;
      end
      ST_RB_RD: begin
        n_addr  = rb_q;
        t_addr  = rb_q;
        state_d = ST_RB_WT;
      end
      ST_RB_WT: begin
        nb_d    = n_rdata;
        t_addr  = rb_q;
        state_d = ST_JOIN;
      end
      ST_JOIN: begin
        // threshold of b still on the read port
        t_addr = rb_q;
        if (join_ok) begin
          n_we = 1'b1;
          if (sets_q != '0) begin
            sets_d = sets_q - 1'b1;
          end
          if (a_wins) begin
            n_addr  = rb_q;
            n_wdata = '{parent: ra_q, rank: nb_q.rank, size: nb_q.size};
            root_d  = ra_q;
            na_d    = '{parent: ra_q, rank: na_q.rank, size: sat_sz};
          end else begin
            n_addr  = ra_q;
            n_wdata = '{parent: rb_q, rank: na_q.rank, size: na_q.size};
            root_d  = rb_q;
            na_d    = '{parent: rb_q,
                        rank: (na_q.rank == nb_q.rank && nb_q.rank != RankMax) ?
                              nb_q.rank + 1'b1 : nb_q.rank,
                        size: sat_sz};
          end
          res_d.merged = 1'b1;
          state_d      = ST_DIV;
          if (item_q.action == ACT_SEGMENT) begin
            div_start = 1'b1;
          end
        end else begin
          cur_d   = ra_q;
          state_d = ST_LBL_RD;
        end
      end
      ST_DIV: begin
        // survivor entry update, then, for a segment merge, wait for the divide
        n_we    = 1'b1;
        n_addr  = root_q;
        n_wdata = na_q;
        if (item_q.action != ACT_SEGMENT) begin
          state_d = ST_OUT;
          res_d.label        = root_q;
          res_d.segment_size = na_q.size;
        end else if (div_done) begin
          state_d = ST_THR_WR;
        end
      end
      ST_THR_WR: begin
        t_we    = 1'b1;
        t_addr  = root_q;
        t_wdata = '{written: 1'b1,
                    thr: thr_sum[ThrBits] ? ThrMax : thr_sum[ThrBits-1:0]};
        res_d.label        = root_q;
        res_d.segment_size = na_q.size;
        state_d            = ST_OUT;
      end
      ST_LBL_RD: begin
        n_addr  = cur_q;
        state_d = ST_LBL_WT;
      end
      ST_LBL_WT: begin
        res_d.merged       = 1'b0;
        res_d.label        = cur_q;
        res_d.segment_size = n_rdata.size;
        state_d            = ST_OUT;
      end
      ST_OUT: begin
        // wait here while the previous beat is still held at the output
        if (!res_vld_q || !out_stall_i) begin
          out_d           = res_q;
          out_d.set_count = sets_q;
          res_vld_d       = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (state_q == ST_IDLE && in_valid_i && !in_stall_o) begin
      res_d.merged = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      sets_q    <= SetReset;
      clr_q     <= '0;
      res_vld_q <= 1'b0;
      mconst_q  <= '0;
      minsz_q   <= '0;
    end else begin
      state_q   <= state_d;
      sets_q    <= sets_d;
      clr_q     <= clr_d;
      res_vld_q <= res_vld_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_MERGE_CONST: mconst_q <= cfg_data_i[ThrBits-1:0];
          REG_MIN_SIZE:    minsz_q  <= cfg_data_i[SizeBits-1:0];
          default:         ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
    out_q  <= out_d;
    cur_q  <= cur_d;
    ra_q   <= ra_d;
    rb_q   <= rb_d;
    root_q <= root_d;
    na_q   <= na_d;
    nb_q   <= nb_d;
    ta_q   <= ta_d;
  end

  // a stalled result beat stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

  // set count only ever falls by one on a merge
  a_sets_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sets_q != $past(sets_q)) |-> (sets_q == $past(sets_q) - 1'b1))
    else $error("set count jumped");

  // input is held off during the clearing pass
  a_clear_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> in_stall_o)
    else $error("input taken during clear");

endmodule
`default_nettype wire

// ===== src/gsuf_ram.sv =====
// single port synchronous ram with registered read
`default_nettype none
module gsuf_ram #(
  parameter int unsigned AddrBits = 16,
  parameter int unsigned DataBits = 8
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [AddrBits-1:0] addr_i,
  input  wire logic [DataBits-1:0] wdata_i,
  output logic      [DataBits-1:0] rdata_o
);
  logic [DataBits-1:0] mem [1<<AddrBits];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule
`default_nettype wire

// ===== src/gsuf_div.sv =====
// restoring divider, one quotient bit per cycle
`default_nettype none
module gsuf_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [gsuf_pkg::ThrBits-1:0] num_i,
  input  wire logic [gsuf_pkg::SizeBits-1:0] den_i,
  output logic                              done_o,
  output logic      [gsuf_pkg::ThrBits-1:0] quo_o
);
  import gsuf_pkg::*;

  localparam int unsigned CntBits = $clog2(ThrBits + 1);

  logic [ThrBits-1:0]  num_q, num_d;
  logic [SizeBits-1:0] den_q, den_d;
  logic [SizeBits:0]   rem_q, rem_d;
  logic [CntBits-1:0]  cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic [SizeBits:0]   trial;

  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[SizeBits-1:0], num_q[ThrBits-1]};
    if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      cnt_d  = CntBits'(ThrBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        num_d = {num_q[ThrBits-2:0], 1'b1};
      end else begin
        rem_d = trial;
        num_d = {num_q[ThrBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign done_o = !busy_q && !start_i;
  assign quo_o  = num_q;
endmodule
`default_nettype wire

// ===== tb/tb_graph_segment_union_find_top.sv =====
// self-checking testbench for the graph segment union-find engine
module tb_graph_segment_union_find_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gsuf_pkg::*;

  // tracks the disjoint-set forest on the side and holds the answers still owed
  class seg_scoreboard;
    logic [VertexBits-1:0] parent_of [Depth];
    logic [RankBits-1:0]   rank_of   [Depth];
    logic [SizeBits-1:0]   size_of   [Depth];
    logic [ThrBits-1:0]    thr_of    [Depth];
    bit                    thr_set   [Depth];
    logic [SizeBits-1:0]   live_segments;
    logic [ThrBits-1:0]    merge_const;
    logic [SizeBits-1:0]   min_size;
    out_item_t             owed_results[$];
    int                    mismatches;
    int                    merges_seen;
    int                    results_seen;

    function new();
      for (int i = 0; i < Depth; i++) begin
        parent_of[i] = VertexBits'(i);
        rank_of[i]   = '0;
        size_of[i]   = SizeBits'(1);
        thr_of[i]    = '0;
        thr_set[i]   = 1'b0;
      end
      live_segments = SetReset;
      merge_const   = '0;
      min_size      = '0;
      mismatches    = 0;
      merges_seen   = 0;
      results_seen  = 0;
    endfunction

    function void apply_setting(reg_idx_e idx, logic [31:0] data);
      if (idx == REG_MERGE_CONST) merge_const = data[ThrBits-1:0];
      else min_size = data[SizeBits-1:0];
    endfunction

    // walk to the root, then point only the starting vertex at it
    function logic [VertexBits-1:0] root_of(logic [VertexBits-1:0] v);
      logic [VertexBits-1:0] y;
      y = v;
      while (parent_of[y] != y) y = parent_of[y];
      parent_of[v] = y;
      return y;
    endfunction

    function logic [ThrBits-1:0] threshold(logic [VertexBits-1:0] r);
      return thr_set[r] ? thr_of[r] : merge_const;
    endfunction

    // join by rank, returns the surviving root
    function logic [VertexBits-1:0] join_roots(logic [VertexBits-1:0] x,
                                               logic [VertexBits-1:0] y);
      logic [SizeBits:0]     total;
      logic [VertexBits-1:0] keep;
      logic [VertexBits-1:0] lose;
      if (rank_of[x] > rank_of[y]) begin
        keep = x;
        lose = y;
      end else begin
        keep = y;
        lose = x;
        if (rank_of[x] == rank_of[y] && rank_of[y] != RankMax) rank_of[y]++;
      end
      parent_of[lose] = keep;
      total = {1'b0, size_of[keep]} + {1'b0, size_of[lose]};
      size_of[keep] = total[SizeBits] ? SizeMax : total[SizeBits-1:0];
      if (live_segments != 0) live_segments--;
      return keep;
    endfunction

    function void note_item(in_item_t it);
      out_item_t             res;
      logic [VertexBits-1:0] ra;
      logic [VertexBits-1:0] rb;
      logic [VertexBits-1:0] r;
      logic [SizeBits-1:0]   s;
      logic [ThrBits:0]      sum;
      bit                    do_join;
      res = '0;
      ra = root_of(it.vertex_a);
      res.label = ra;
      if (it.action == ACT_SEGMENT || it.action == ACT_SMALL) begin
        rb = root_of(it.vertex_b);
        if (ra != rb) begin
          if (it.action == ACT_SEGMENT)
            do_join = ThrBits'(it.edge_weight) <= threshold(ra) &&
                      ThrBits'(it.edge_weight) <= threshold(rb);
          else
            do_join = size_of[ra] < min_size || size_of[rb] < min_size;
          if (do_join) begin
            r = join_roots(ra, rb);
            res.merged = 1'b1;
            res.label  = r;
            merges_seen++;
            if (it.action == ACT_SEGMENT) begin
              s = (size_of[r] == 0) ? SizeBits'(1) : size_of[r];
              sum = (ThrBits+1)'(it.edge_weight) + (ThrBits+1)'(merge_const / s);
              thr_of[r]  = sum[ThrBits] ? ThrMax : sum[ThrBits-1:0];
              thr_set[r] = 1'b1;
            end
          end
        end
      end
      res.segment_size = size_of[res.label];
      res.set_count    = live_segments;
      owed_results.push_back(res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      results_seen++;
      if (owed_results.size() == 0) begin
        $display("%0t ERROR unexpected result %p", $time, got);
        mismatches++;
        return;
      end
      want = owed_results.pop_front();
      if (got.merged !== want.merged) begin
        $display("%0t ERROR merged exp %0d got %0d", $time, want.merged, got.merged);
        mismatches++;
      end
      if (got.label !== want.label) begin
        $display("%0t ERROR label exp %0d got %0d", $time, want.label, got.label);
        mismatches++;
      end
      if (got.segment_size !== want.segment_size) begin
        $display("%0t ERROR segment_size exp %0d got %0d", $time,
                 want.segment_size, got.segment_size);
        mismatches++;
      end
      if (got.set_count !== want.set_count) begin
        $display("%0t ERROR set_count exp %0d got %0d", $time,
                 want.set_count, got.set_count);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_item_t   out_data_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  graph_segment_union_find_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  seg_scoreboard forest = new();

  // idling knobs, percent of cycles, changed per phase
  int gap_pct   = 0;
  int stall_pct = 0;
  // long receiver hold-off, counted down by the result side
  int hold_left = 0;
  int beats_in  = 0;

  // 8 ns clock
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // every input known from time zero
  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
  end

  // result side: check each beat, then choose the next stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) forest.check_result(out_data_o);
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // offer one item and hold it until the engine takes it
  task automatic send_item(input in_item_t it);
    in_data_i  <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    forest.note_item(it);
    beats_in++;
    // random sender gaps, falling at any point of the engine's work
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    forest.apply_setting(idx, data);
    cfg_valid_i <= 1'b0;
  endtask

  // settle: all answers in and the engine back at rest before a register write
  task automatic drain();
    in_valid_i <= 1'b0;
    while (forest.owed_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic in_item_t make_item(action_e act, int a, int b, int w);
    in_item_t it;
    it.action      = act;
    it.vertex_a    = VertexBits'(a);
    it.vertex_b    = VertexBits'(b);
    it.edge_weight = WeightBits'(w);
    return it;
  endfunction

  // random phase: sorted edges over a small vertex pool so segments really grow
  task automatic random_phase(input int n_items);
    int       base;
    int       weight;
    int       pick;
    in_item_t it;
    base   = $urandom_range(0, Depth - 65);
    weight = 0;
    for (int k = 0; k < n_items; k++) begin
      weight += $urandom_range(0, 1500);
      if (weight > 18'h3FFFF) weight = 18'h3FFFF;
      pick = $urandom_range(0, 99);
      it = make_item(ACT_SEGMENT, base + $urandom_range(0, 63),
                     base + $urandom_range(0, 63), weight);
      if (pick >= 60 && pick < 80) it.action = ACT_SMALL;
      else if (pick >= 80 && pick < 95) it.action = ACT_QUERY;
      else if (pick >= 95) it.action = ACT_SPARE;
      // noise: any vertex, any weight out of order
      if ($urandom_range(0, 9) == 0) begin
        it.vertex_a    = VertexBits'($urandom);
        it.vertex_b    = VertexBits'($urandom);
        it.edge_weight = WeightBits'($urandom);
      end
      send_item(it);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, all actions, threshold and small-segment rules
    write_reg(REG_MERGE_CONST, 32'h0001_0000);
    write_reg(REG_MIN_SIZE, 32'd2);
    send_item(make_item(ACT_QUERY, 0, 0, 0));
    send_item(make_item(ACT_QUERY, 16'hFFFF, 16'hFFFF, 18'h3FFFF));
    send_item(make_item(ACT_SPARE, 16'hFFFF, 0, 0));
    send_item(make_item(ACT_SEGMENT, 0, 16'hFFFF, 0));          // joins
    send_item(make_item(ACT_SEGMENT, 16'hFFFF, 0, 0));          // same root already
    send_item(make_item(ACT_SEGMENT, 5, 5, 0));                 // self edge
    send_item(make_item(ACT_SEGMENT, 1, 2, 18'h10000));         // weight equals threshold
    send_item(make_item(ACT_SEGMENT, 3, 4, 18'h10001));         // just above threshold
    send_item(make_item(ACT_SEGMENT, 1, 0, 18'h10000));         // against size-scaled bonus
    send_item(make_item(ACT_SEGMENT, 6, 7, 18'h3FFFF));         // max weight refused
    send_item(make_item(ACT_SMALL, 3, 4, 18'h3FFFF));           // singletons below min size
    send_item(make_item(ACT_SMALL, 1, 3, 0));                   // both at min size, refused
    send_item(make_item(ACT_SMALL, 8, 1, 0));                   // one side small
    send_item(make_item(ACT_SMALL, 9, 9, 0));
    send_item(make_item(ACT_QUERY, 4, 0, 0));
    send_item(make_item(ACT_SPARE, 16'hFFFF, 16'hFFFF, 18'h3FFFF));
    send_item(make_item(ACT_QUERY, 16'hAAAA, 16'h5555, 18'h2AAAA));
    send_item(make_item(ACT_QUERY, 16'h5555, 16'hAAAA, 18'h15555));
    drain();

    // threshold zero, small-segment pass off, no idling
    write_reg(REG_MERGE_CONST, 32'h0);
    write_reg(REG_MIN_SIZE, 32'h0);
    random_phase(200);
    drain();

    // largest constant, min size equal to the vertex count, sender idle most of the time
    write_reg(REG_MERGE_CONST, 32'h00FF_FFFF);
    write_reg(REG_MIN_SIZE, 32'd65536);
    gap_pct = 76;
    random_phase(200);
    drain();

    // mid settings, receiver stalling most of the time
    write_reg(REG_MERGE_CONST, 32'h0003_0000);
    write_reg(REG_MIN_SIZE, 32'd8);
    gap_pct   = 0;
    stall_pct = 76;
    random_phase(200);
    drain();

    write_reg(REG_MERGE_CONST, 32'h0000_8000);
    write_reg(REG_MIN_SIZE, 32'd1);
    gap_pct   = 20;
    stall_pct = 20;
    random_phase(200);
    drain();

    // random settings with junk upper bits; long hold-off backs the engine up
    write_reg(REG_MERGE_CONST, $urandom);
    write_reg(REG_MIN_SIZE, $urandom);
    gap_pct   = 0;
    stall_pct = 0;
    hold_left = 600;
    random_phase(200);
    drain();

    $display("covered %0d items, %0d results, %0d merges, across six settings",
             beats_in, forest.results_seen, forest.merges_seen);
    $display("idle phases: none, sender 76%%, receiver 76%%, both 20%%, long hold-off");
    if (forest.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run including the clearing pass
  initial begin
    #50_000_000;
    $display("timeout with %0d results outstanding", forest.owed_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
